FILE: sv/nbq_pkg.sv
// ----------------------------------------------------------------------------
// nbq_pkg
// Shared types, register indexes and name encoding for the name query
// responder.
// ----------------------------------------------------------------------------
package nbq_pkg;

  localparam int unsigned POS_W = 6;
  localparam logic [POS_W-1:0] RESP_LEN      = 6'd62;
  localparam logic [POS_W-1:0] RESP_LAST_POS = 6'd61;
  localparam logic [POS_W-1:0] MIN_MATCH_LEN = 6'd50;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LOW  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LEN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANSWER_IP = 8'd3;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef struct packed {
    logic [63:0] chars_low;
    logic [55:0] chars_high;
    logic [3:0]  name_len;
    logic [31:0] answer_ip;
  } cfg_t;

  // Fields echoed into a response, handed from the receive side at start.
  typedef struct packed {
    logic [15:0] trans_id;
    logic [15:0] auth_cnt;
    logic [15:0] addl_cnt;
    logic [31:0] dest_ip;
  } resp_ctx_t;

  // Upper-cased, space-padded name character; the sixteenth is zero.
  function automatic logic [7:0] name_char(cfg_t cfg, logic [3:0] idx);
    logic [119:0] chars;
    logic [6:0]   base;
    logic [7:0]   ch;
    chars = {cfg.chars_low, cfg.chars_high};
    base  = 7'(7'd119 - {idx, 3'b000});
    ch    = chars[base -: 8];
    if (ch >= 8'h61 && ch <= 8'h7a) begin
      ch = ch - 8'h20;
    end
    if (idx == 4'hf) begin
      ch = 8'h00;
    end else if (idx >= cfg.name_len) begin
      ch = CHAR_SPACE;
    end
    return ch;
  endfunction

  // First-level encoded name byte k (0..31).
  function automatic logic [7:0] enc_byte(cfg_t cfg, logic [4:0] k);
    logic [7:0] ch;
    ch = name_char(cfg, k[4:1]);
    if (k[0]) begin
      return {4'h0, ch[3:0]} + CHAR_A;
    end
    return {4'h0, ch[7:4]} + CHAR_A;
  endfunction

endpackage

FILE: sv/nbq_cfg.sv
// ----------------------------------------------------------------------------
// nbq_cfg
// Configuration register file: name characters, name length, answer address.
// ----------------------------------------------------------------------------
module nbq_cfg import nbq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NAME_LOW:  cfg_d.chars_low  = cfg_data_i;
        CFG_NAME_HIGH: cfg_d.chars_high = cfg_data_i[55:0];
        CFG_NAME_LEN:  cfg_d.name_len   = cfg_data_i[3:0];
        CFG_ANSWER_IP: cfg_d.answer_ip  = cfg_data_i[31:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/nbq_rx.sv
// ----------------------------------------------------------------------------
// nbq_rx
// Request checker: tracks byte position, match flag and the echoed header
// fields; pulses start on the last byte of a matching query.
// ----------------------------------------------------------------------------
module nbq_rx import nbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  input  logic [31:0] src_ip_i,
  output logic        start_o,
  output resp_ctx_t   ctx_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic             match_q, match_d;
  resp_ctx_t        ctx_q, ctx_d;
  logic             in_range;
  logic             byte_ok;
  logic [POS_W-1:0] pos_next;
  logic             match_next;
  logic [4:0]       enc_idx;

  assign in_range = (pos_q < RESP_LEN);
  assign enc_idx  = 5'(pos_q - 6'd13);

  always_comb begin
    case (pos_q) inside
      [6'd13:6'd44]: byte_ok = (rx_byte_i == enc_byte(cfg_i, enc_idx));
      6'd2:          byte_ok = (rx_byte_i[7:3] == 5'd0);
      6'd4:          byte_ok = (rx_byte_i == 8'h00);
      6'd5:          byte_ok = (rx_byte_i == 8'h01);
      6'd12:         byte_ok = (rx_byte_i == 8'h20);
      6'd45, 6'd46:  byte_ok = (rx_byte_i == 8'h00);
      6'd47:         byte_ok = (rx_byte_i == 8'h20);
      6'd48:         byte_ok = (rx_byte_i == 8'h00);
      6'd49:         byte_ok = (rx_byte_i == 8'h01);
      default:       byte_ok = 1'b1;
    endcase
  end

  assign pos_next   = in_range ? pos_q + 6'd1 : pos_q;
  assign match_next = match_q && (!in_range || byte_ok);

  always_comb begin
    pos_d   = pos_q;
    match_d = match_q;
    ctx_d   = ctx_q;
    start_o = 1'b0;
    if (accept_i) begin
      if (in_range) begin
        case (pos_q)
          6'd0: begin
            ctx_d.dest_ip        = src_ip_i;
            ctx_d.trans_id[15:8] = rx_byte_i;
          end
          6'd1:  ctx_d.trans_id[7:0]  = rx_byte_i;
          6'd8:  ctx_d.auth_cnt[15:8] = rx_byte_i;
          6'd9:  ctx_d.auth_cnt[7:0]  = rx_byte_i;
          6'd10: ctx_d.addl_cnt[15:8] = rx_byte_i;
          6'd11: ctx_d.addl_cnt[7:0]  = rx_byte_i;
          default: ;
        endcase
      end
      pos_d   = pos_next;
      match_d = match_next;
      if (rx_last_i) begin
        // end of datagram: restart for the next one
        start_o = match_next && (pos_next >= MIN_MATCH_LEN);
        pos_d   = '0;
        match_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      match_q <= 1'b1;
      ctx_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      match_q <= match_d;
      ctx_q   <= ctx_d;
    end
  end

  // header fields never change on the last byte of a match, so the
  // current values are the ones to echo
  assign ctx_o = ctx_q;

endmodule

FILE: sv/nbq_tx.sv
// ----------------------------------------------------------------------------
// nbq_tx
// Response generator: holds a snapshot of the echoed fields and steps
// through the 62 response bytes, one per output transaction.
// ----------------------------------------------------------------------------
module nbq_tx import nbq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        start_i,
  input  resp_ctx_t   ctx_i,
  output logic        busy_o,
  output logic        resp_valid_o,
  input  logic        resp_ready_i,
  output logic [7:0]  resp_byte_o,
  output logic        resp_last_o,
  output logic [31:0] dest_ip_o
);

  logic             busy_q, busy_d;
  logic [POS_W-1:0] idx_q, idx_d;
  resp_ctx_t        ctx_q, ctx_d;
  logic             is_last;
  logic [4:0]       enc_idx;
  logic [7:0]       byte_val;

  assign is_last = (idx_q == RESP_LAST_POS);
  assign enc_idx = 5'(idx_q - 6'd13);

  always_comb begin
    case (idx_q) inside
      [6'd13:6'd44]: byte_val = enc_byte(cfg_i, enc_idx);
      6'd0:          byte_val = ctx_q.trans_id[15:8];
      6'd1:          byte_val = ctx_q.trans_id[7:0];
      6'd2:          byte_val = 8'h85;
      6'd3:          byte_val = 8'h80;
      6'd7:          byte_val = 8'h01;
      6'd8:          byte_val = ctx_q.auth_cnt[15:8];
      6'd9:          byte_val = ctx_q.auth_cnt[7:0];
      6'd10:         byte_val = ctx_q.addl_cnt[15:8];
      6'd11:         byte_val = ctx_q.addl_cnt[7:0];
      6'd12, 6'd47:  byte_val = 8'h20;
      6'd49:         byte_val = 8'h01;
      6'd53:         byte_val = 8'd60;
      6'd55:         byte_val = 8'd6;
      6'd58:         byte_val = cfg_i.answer_ip[31:24];
      6'd59:         byte_val = cfg_i.answer_ip[23:16];
      6'd60:         byte_val = cfg_i.answer_ip[15:8];
      6'd61:         byte_val = cfg_i.answer_ip[7:0];
      default:       byte_val = 8'h00;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ctx_d  = ctx_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      ctx_d  = ctx_i;
    end else if (busy_q && resp_ready_i) begin
      if (is_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ctx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ctx_q  <= ctx_d;
    end
  end

  assign busy_o       = busy_q;
  assign resp_valid_o = busy_q;
  assign resp_byte_o  = byte_val;
  assign resp_last_o  = is_last;
  assign dest_ip_o    = ctx_q.dest_ip;

endmodule

FILE: sv/netbios_name_query_responder_top.sv
// ----------------------------------------------------------------------------
// netbios_name_query_responder_top
// Checks a received name service query byte by byte and answers a match
// with the 62-byte positive name query response.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  rx       | in        | rx_valid_i/rx_ready_o | rx_byte_i rx_last_i src_ip_i
//  resp     | out       | resp_valid_o/_ready_i | resp_byte_o resp_last_o dest_ip_o
//  cfg      | in        | cfg_valid_i/_ready_o  | cfg_index_i cfg_data_i
//
//  One request byte is taken per cycle while no response is in flight.
//  The last byte of a matching query starts the response on the next cycle;
//  its 62 bytes then leave at one per cycle while resp_ready_i is high.
//  rx_ready_o stays low until the final response transaction completes.
//  A stall on resp holds the current byte. Reset clears all state at once.
// ----------------------------------------------------------------------------
module netbios_name_query_responder_top import nbq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 rx_last_i,
  input  logic [31:0]          src_ip_i,
  output logic                 resp_valid_o,
  input  logic                 resp_ready_i,
  output logic [7:0]           resp_byte_o,
  output logic                 resp_last_o,
  output logic [31:0]          dest_ip_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  cfg_t      cfg;
  resp_ctx_t ctx;
  logic      start;
  logic      busy;
  logic      rx_accept;

  assign cfg_ready_o = 1'b1;
  assign rx_ready_o  = !busy;
  assign rx_accept   = rx_valid_i && !busy;

  nbq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  nbq_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (rx_accept),
    .rx_byte_i (rx_byte_i),
    .rx_last_i (rx_last_i),
    .src_ip_i  (src_ip_i),
    .start_o   (start),
    .ctx_o     (ctx)
  );

  nbq_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .start_i      (start),
    .ctx_i        (ctx),
    .busy_o       (busy),
    .resp_valid_o (resp_valid_o),
    .resp_ready_i (resp_ready_i),
    .resp_byte_o  (resp_byte_o),
    .resp_last_o  (resp_last_o),
    .dest_ip_o    (dest_ip_o)
  );

endmodule

FILE: dv/nbq_resp_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nbq_resp_checker
// Watches the request, response and register channels of the name query
// responder, predicts every response byte and compares it field by field.
// ----------------------------------------------------------------------------

// Name encoding shared by the stimulus and the predictor.
package nbq_tb_pkg;
  import nbq_pkg::*;

  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7a;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] NAME_LEN_FIELD = 8'h20;
  localparam logic [7:0] NB_TYPE   = 8'h20;
  localparam logic [7:0] IN_CLASS  = 8'h01;
  localparam logic [7:0] FLAGS_HI  = 8'h85;
  localparam logic [7:0] FLAGS_LO  = 8'h80;
  localparam logic [7:0] ANCOUNT   = 8'h01;
  localparam logic [7:0] QDCOUNT   = 8'h01;
  localparam logic [7:0] TTL_SEC   = 8'd60;
  localparam logic [7:0] RDATA_LEN = 8'd6;

  // Byte k (0..31) of the first-level encoded, space-padded name.
  function automatic logic [7:0] encoded_name_byte(logic [63:0] lo, logic [55:0] hi,
                                                   logic [3:0] len, int unsigned k);
    int unsigned idx;
    logic [7:0]  ch;
    idx = k / 2;
    if (idx >= 15) begin
      ch = 8'h00;
    end else if (idx >= len) begin
      ch = CHAR_SPACE;
    end else begin
      if (idx < 8) begin
        ch = lo[63 - 8 * idx -: 8];
      end else begin
        ch = hi[55 - 8 * (idx - 8) -: 8];
      end
      if (ch >= LOWER_A && ch <= LOWER_Z) begin
        ch = ch - CASE_BIT;
      end
    end
    if (k % 2 == 1) begin
      return {4'h0, ch[3:0]} + CHAR_A;
    end
    return {4'h0, ch[7:4]} + CHAR_A;
  endfunction

endpackage

module nbq_resp_checker
  import nbq_pkg::*;
  import nbq_tb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rx_valid_i,
  input  logic                 rx_ready_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 rx_last_i,
  input  logic [31:0]          src_ip_i,
  input  logic                 resp_valid_i,
  input  logic                 resp_ready_i,
  input  logic [7:0]           resp_byte_i,
  input  logic                 resp_last_i,
  input  logic [31:0]          dest_ip_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o,
  output int unsigned          checked_o,
  output int unsigned          answers_o
);

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] ip;
  } resp_beat_t;

  logic [63:0] name_lo   = '0;
  logic [55:0] name_hi   = '0;
  logic [3:0]  name_len  = '0;
  logic [31:0] answer_ip = '0;

  int unsigned rx_pos    = 0;
  logic        query_ok  = 1'b1;
  logic [15:0] trans_id  = '0;
  logic [15:0] auth_cnt  = '0;
  logic [15:0] addl_cnt  = '0;
  logic [31:0] sender_ip = '0;

  resp_beat_t answer_q[$];

  function automatic logic [7:0] name_byte(int unsigned k);
    return encoded_name_byte(name_lo, name_hi, name_len, k);
  endfunction

  function automatic logic request_byte_ok(int unsigned p, logic [7:0] data);
    if (p >= 13 && p <= 44) begin
      return data == name_byte(p - 13);
    end
    case (p)
      2:           return data[7:3] == 5'b0;
      4, 45, 46, 48: return data == 8'h00;
      5:           return data == QDCOUNT;
      12:          return data == NAME_LEN_FIELD;
      47:          return data == NB_TYPE;
      49:          return data == IN_CLASS;
      default:     return 1'b1;
    endcase
  endfunction

  function automatic logic [7:0] answer_byte(int unsigned k);
    if (k >= 13 && k <= 44) begin
      return name_byte(k - 13);
    end
    case (k)
      0:       return trans_id[15:8];
      1:       return trans_id[7:0];
      2:       return FLAGS_HI;
      3:       return FLAGS_LO;
      7:       return ANCOUNT;
      8:       return auth_cnt[15:8];
      9:       return auth_cnt[7:0];
      10:      return addl_cnt[15:8];
      11:      return addl_cnt[7:0];
      12:      return NAME_LEN_FIELD;
      47:      return NB_TYPE;
      49:      return IN_CLASS;
      53:      return TTL_SEC;
      55:      return RDATA_LEN;
      58:      return answer_ip[31:24];
      59:      return answer_ip[23:16];
      60:      return answer_ip[15:8];
      61:      return answer_ip[7:0];
      default: return 8'h00;
    endcase
  endfunction

  // Advance the request parser by one byte; queue the answer on a match.
  function automatic void step_request(logic [7:0] data, logic last, logic [31:0] ip);
    if (rx_pos < RESP_LEN) begin
      if (rx_pos == 0) begin
        sender_ip = ip;
      end
      if (!request_byte_ok(rx_pos, data)) begin
        query_ok = 1'b0;
      end
      case (rx_pos)
        0:       trans_id[15:8] = data;
        1:       trans_id[7:0]  = data;
        8:       auth_cnt[15:8] = data;
        9:       auth_cnt[7:0]  = data;
        10:      addl_cnt[15:8] = data;
        11:      addl_cnt[7:0]  = data;
        default: ;
      endcase
      rx_pos++;
    end
    if (last) begin
      // a short datagram reads its class as zero and cannot match
      if (query_ok && rx_pos >= MIN_MATCH_LEN) begin
        for (int unsigned k = 0; k < RESP_LEN; k++) begin
          answer_q.push_back(resp_beat_t'{data: answer_byte(k),
                                          last: (k == RESP_LAST_POS),
                                          ip:   sender_ip});
        end
        answers_o++;
      end
      rx_pos   = 0;
      query_ok = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_beat_t want;
    if (!rst_ni) begin
      name_lo   = '0;
      name_hi   = '0;
      name_len  = '0;
      answer_ip = '0;
      rx_pos    = 0;
      query_ok  = 1'b1;
      trans_id  = '0;
      auth_cnt  = '0;
      addl_cnt  = '0;
      sender_ip = '0;
      answer_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_NAME_LOW:  name_lo   = cfg_data_i;
          CFG_NAME_HIGH: name_hi   = cfg_data_i[55:0];
          CFG_NAME_LEN:  name_len  = cfg_data_i[3:0];
          CFG_ANSWER_IP: answer_ip = cfg_data_i[31:0];
          default: ;
        endcase
      end
      // drain responses before parsing: a byte taken now cannot be answered now
      if (resp_valid_i && resp_ready_i) begin
        if (answer_q.size() == 0) begin
          $error("response transaction with no answer pending (resp_byte %02h)",
                 resp_byte_i);
          fail_count_o++;
        end else begin
          want = answer_q.pop_front();
          checked_o++;
          if (resp_byte_i !== want.data) begin
            $error("resp_byte mismatch: expected %02h, actual %02h", want.data, resp_byte_i);
            fail_count_o++;
          end
          if (resp_last_i !== want.last) begin
            $error("resp_last mismatch: expected %0b, actual %0b", want.last, resp_last_i);
            fail_count_o++;
          end
          if (dest_ip_i !== want.ip) begin
            $error("dest_ip mismatch: expected %08h, actual %08h", want.ip, dest_ip_i);
            fail_count_o++;
          end
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        step_request(rx_byte_i, rx_last_i, src_ip_i);
      end
    end
    pending_o = answer_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds name service datagrams to the name query responder: directed queries
// at the register and field extremes, then random well-formed, damaged, short
// and noise datagrams under random names, with bursty input and a stalling
// response sink. Prediction and comparison sit in nbq_resp_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import nbq_pkg::*;
  import nbq_tb_pkg::*;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned RAND_PHASES    = 2;
  localparam int unsigned BYTES_PER_PHASE = 60;

  typedef enum int unsigned {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARE} ready_mode_e;
  typedef enum int unsigned {PKT_GOOD, PKT_DAMAGED, PKT_SHORT, PKT_NOISE} pkt_kind_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 rx_valid   = 1'b0;
  logic                 rx_ready;
  logic [7:0]           rx_byte    = '0;
  logic                 rx_last    = 1'b0;
  logic [31:0]          src_ip     = '0;
  logic                 resp_valid;
  logic                 resp_ready = 1'b0;
  logic [7:0]           resp_byte;
  logic                 resp_last;
  logic [31:0]          dest_ip;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [63:0]          cfg_data   = '0;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked_cnt;
  int unsigned answer_cnt;

  // stimulus-side copy of the name, used to build matching queries
  logic [63:0] cur_lo  = '0;
  logic [55:0] cur_hi  = '0;
  logic [3:0]  cur_len = '0;

  logic [7:0]  pkt_q[$];
  int unsigned burst_left   = 0;
  int unsigned bytes_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned settings_cnt = 0;
  int unsigned cycle_cnt    = 0;

  ready_mode_e ready_mode = READY_ALWAYS;
  int unsigned ready_left = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  netbios_name_query_responder_top dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_valid_i   (rx_valid),
    .rx_ready_o   (rx_ready),
    .rx_byte_i    (rx_byte),
    .rx_last_i    (rx_last),
    .src_ip_i     (src_ip),
    .resp_valid_o (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_byte_o  (resp_byte),
    .resp_last_o  (resp_last),
    .dest_ip_o    (dest_ip),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  nbq_resp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .rx_valid_i   (rx_valid),
    .rx_ready_i   (rx_ready),
    .rx_byte_i    (rx_byte),
    .rx_last_i    (rx_last),
    .src_ip_i     (src_ip),
    .resp_valid_i (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_byte_i  (resp_byte),
    .resp_last_i  (resp_last),
    .dest_ip_i    (dest_ip),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_cnt),
    .pending_o    (pending),
    .checked_o    (checked_cnt),
    .answers_o    (answer_cnt)
  );

  // Response sink: switch between stall patterns every so often.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 150);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: resp_ready <= 1'b1;
      READY_HALF:   resp_ready <= 1'($urandom_range(0, 1));
      READY_MOSTLY: resp_ready <= ($urandom_range(0, 7) != 0);
      default:      resp_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answer bytes outstanding", cycle_cnt, pending);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] any_ip();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] any_name_char();
    case ($urandom_range(0, 3))
      0:       return 8'(LOWER_A + $urandom_range(0, 25));
      1:       return 8'(CHAR_A + $urandom_range(0, 25));
      2:       return 8'(8'h30 + $urandom_range(0, 9));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] any_name_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) begin
      w = {w[55:0], any_name_char()};
    end
    return w;
  endfunction

  function automatic int unsigned query_len();
    if ($urandom_range(0, 5) == 0) begin
      return $urandom_range(63, 80);
    end
    return $urandom_range(50, 62);
  endfunction

  // Write all four registers back to back; junk in the unused upper bits.
  task automatic program_regs(logic [63:0] lo, logic [55:0] hi, logic [3:0] len,
                              logic [31:0] ip);
    logic [63:0]          junk;
    logic [63:0]          vals[4];
    logic [CFG_IDX_W-1:0] idxs[4];
    junk = {$urandom, $urandom};
    vals = '{lo, {junk[63:56], hi}, {junk[63:4], len}, {junk[63:32], ip}};
    idxs = '{CFG_NAME_LOW, CFG_NAME_HIGH, CFG_NAME_LEN, CFG_ANSWER_IP};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_lo  = lo;
    cur_hi  = hi;
    cur_len = len;
    settings_cnt++;
  endtask

  task automatic send_byte(logic [7:0] data, logic last, logic [31:0] ip);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        rx_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_valid <= 1'b1;
    rx_byte  <= data;
    rx_last  <= last;
    src_ip   <= ip;
    do @(posedge clk); while (!rx_ready);
    bytes_sent++;
  endtask

  task automatic send_packet(logic [31:0] ip);
    foreach (pkt_q[i]) begin
      send_byte(pkt_q[i], i == pkt_q.size() - 1, ip);
    end
    packets_sent++;
  endtask

  // Hold the sender until every answer is out, then let the block settle.
  task automatic wait_drained();
    rx_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Well-formed query for the current name, cut or padded to total bytes.
  task automatic make_query(int unsigned total, logic [15:0] tid, logic [15:0] auth,
                            logic [15:0] addl);
    logic [7:0] r;
    pkt_q.delete();
    pkt_q.push_back(tid[15:8]);
    pkt_q.push_back(tid[7:0]);
    r = 8'($urandom);
    pkt_q.push_back(r & 8'h07);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(8'h00);
    pkt_q.push_back(QDCOUNT);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(auth[15:8]);
    pkt_q.push_back(auth[7:0]);
    pkt_q.push_back(addl[15:8]);
    pkt_q.push_back(addl[7:0]);
    pkt_q.push_back(NAME_LEN_FIELD);
    for (int unsigned k = 0; k < 32; k++) begin
      pkt_q.push_back(encoded_name_byte(cur_lo, cur_hi, cur_len, k));
    end
    pkt_q.push_back(8'h00);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(NB_TYPE);
    pkt_q.push_back(8'h00);
    pkt_q.push_back(IN_CLASS);
    while (pkt_q.size() < total) pkt_q.push_back(8'($urandom));
    while (pkt_q.size() > total) void'(pkt_q.pop_back());
  endtask

  // Spoil one checked byte of a full-length query.
  task automatic damage_query();
    int unsigned p;
    logic [7:0]  flip;
    case ($urandom_range(0, 4))
      0:       p = 2;
      1:       p = 4 + $urandom_range(0, 1);
      2:       p = 12;
      3:       p = 13 + $urandom_range(0, 31);
      default: p = 45 + $urandom_range(0, 4);
    endcase
    if (p == 2) begin
      flip = 8'h08 << $urandom_range(0, 4);
    end else begin
      flip = 8'($urandom_range(1, 255));
    end
    pkt_q[p] = pkt_q[p] ^ flip;
  endtask

  initial begin
    pkt_kind_e   kind;
    int unsigned phase_start;
    int unsigned sel;
    rst_n <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty name, so all fifteen characters are spaces.
    make_query(50, 16'hFFFF, 16'h0000, 16'hFFFF);
    send_packet(32'hFFFF_FFFF);
    pkt_q = '{8'hFF};
    send_packet(32'h0000_0000);
    wait_drained();

    // Lower-case configured name, full length with bytes past the end,
    // then one byte too short.
    program_regs(64'h6162_6364_6566_6768, 56'h69_6a6b_6c6d_6e6f, 4'd15, 32'hFFFF_FFFF);
    make_query(64, 16'h0000, 16'hFFFF, 16'h0000);
    send_packet(32'h0000_0000);
    make_query(49, 16'hABCD, 16'h0001, 16'h0002);
    send_packet(any_ip());
    wait_drained();

    // Zero characters are encoded as they are.
    program_regs('0, '0, 4'd15, 32'h0000_0000);
    make_query(50, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_packet(any_ip());
    wait_drained();

    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      program_regs(any_name_word(), 56'(any_name_word()), 4'($urandom), $urandom);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
        sel  = $urandom_range(0, 19);
        kind = (sel < 13) ? PKT_GOOD : (sel < 16) ? PKT_DAMAGED :
               (sel < 18) ? PKT_SHORT : PKT_NOISE;
        case (kind)
          PKT_GOOD: make_query(query_len(), 16'($urandom), 16'($urandom), 16'($urandom));
          PKT_DAMAGED: begin
            make_query(query_len(), 16'($urandom), 16'($urandom), 16'($urandom));
            damage_query();
          end
          PKT_SHORT: make_query($urandom_range(1, 49), 16'($urandom), 16'($urandom),
                                16'($urandom));
          default: begin
            pkt_q.delete();
            repeat ($urandom_range(1, 8)) pkt_q.push_back(8'($urandom));
          end
        endcase
        send_packet(any_ip());
        if ($urandom_range(0, 7) == 0) begin
          wait_drained();
        end
      end
      wait_drained();
    end

    wait_drained();
    $display("Sent %0d request bytes in %0d datagrams under %0d name settings.",
             bytes_sent, packets_sent, settings_cnt);
    $display("Checked %0d response bytes from %0d positive answers.",
             checked_cnt, answer_cnt);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/nbq_pkg.sv
sv/nbq_cfg.sv
sv/nbq_rx.sv
sv/nbq_tx.sv
sv/netbios_name_query_responder_top.sv
dv/nbq_resp_checker.sv
dv/tb_top.sv
